// File: rtl/chi_square_pair_independence_macros.svh
// Assertion macros shared by the chi-square pair block
`ifndef CHI_SQUARE_PAIR_INDEPENDENCE_MACROS_SVH
`define CHI_SQUARE_PAIR_INDEPENDENCE_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define CSPI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cspi assertion failed");
// next-cycle implication, checked out of reset
`define CSPI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cspi assertion failed");
`else
`define CSPI_ASSERT_IMP(lbl, ante, cons)
`define CSPI_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: rtl/cspi_pkg.sv
// Types and fixed constants of the chi-square pair block
`timescale 1ns / 1ps
package cspi_pkg;

	// result format: unsigned Q19.16
	localparam int STAT_BITS = 35;
	localparam int FRAC_BITS = 16;
	localparam int QUO_BITS  = STAT_BITS + 1;
	localparam logic [STAT_BITS-1:0] STAT_MAX = '1;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_INC,
		ST_BEGIN,
		ST_RD,
		ST_LAT,
		ST_MUL,
		ST_DIV,
		ST_ACC,
		ST_NEXT,
		ST_OUT
	} state_t;

	// destination of a registered product
	typedef enum logic [2:0] {
		TAG_NONE,
		TAG_P,
		TAG_OT,
		TAG_DEN,
		TAG_NUM
	} tag_t;

	// partial product shift, in units of the count width
	typedef logic [1:0] shift_t;
	localparam shift_t SH0 = 2'd0;
	localparam shift_t SH1 = 2'd1;
	localparam shift_t SH2 = 2'd2;

	// multiply sequence steps for one cell
	typedef logic [3:0] mstep_t;
	localparam mstep_t MS_P    = 4'd0;
	localparam mstep_t MS_OT   = 4'd1;
	localparam mstep_t MS_DEN0 = 4'd2;
	localparam mstep_t MS_DEN1 = 4'd3;
	localparam mstep_t MS_NUM0 = 4'd4;
	localparam mstep_t MS_NUM1 = 4'd5;
	localparam mstep_t MS_NUM2 = 4'd6;
	localparam mstep_t MS_NUM3 = 4'd7;
	localparam mstep_t MS_WAIT = 4'd8;
	localparam mstep_t MS_LOAD = 4'd9;

endpackage

// File: rtl/cspi_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module cspi_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/chi_square_pair_independence.sv
// Top level: contingency counting and iterative chi-square evaluation
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------------
//  row in   | start && !busy       | value_a, value_b, last_row
//  result   | done (one cycle)     | statistic, no_data, range_error, count_overflow
//
// A counted row reads the cell and both margin RAMs, then writes them back
// incremented. A row that is not counted and not last keeps the block idle.
// On the last row, unless nothing was counted, a pass over all K*K cells runs on
// one shared CB x CB multiplier and a one-bit-per-cycle restoring divider; a cell
// with zero expected count skips the divide, and the pass stops early on a
// saturating term. Then the result beat, then a clear sweep of the count RAMs
// (skipped when nothing was counted). After reset the same sweep runs.
// busy is high through all of it; the result beat cannot be stalled.
`timescale 1ns / 1ps
`include "chi_square_pair_independence_macros.svh"
module chi_square_pair_independence import cspi_pkg::*; #(
	parameter int MAX_CATEGORY = 8,
	parameter int COUNT_BITS   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [7:0]           value_a,
	input  logic [7:0]           value_b,
	input  logic                 last_row,
	output logic                 done,
	output logic [STAT_BITS-1:0] statistic,
	output logic                 no_data,
	output logic                 range_error,
	output logic                 count_overflow
);

	localparam int K     = MAX_CATEGORY;
	localparam int CB    = COUNT_BITS;
	localparam int CELLS = K * K;
	localparam int CAW   = $clog2(CELLS);
	localparam int RAW   = $clog2(K);
	localparam int WW    = 4 * CB + QUO_BITS;
	localparam logic [CB-1:0]  COUNT_MAX = '1;
	localparam logic [CAW-1:0] LAST_CELL = CAW'(CELLS - 1);
	localparam logic [RAW-1:0] LAST_IDX  = RAW'(K - 1);
	localparam logic [CAW-1:0] K_CELL    = CAW'(K);
	localparam logic [7:0]     K_VAL     = 8'(K);

	state_t state_q, state_d;

	// input classification
	logic           accept, bad, present, at_limit, counted;
	logic [RAW-1:0] am1, bm1;
	logic [CAW-1:0] cell_in;

	// control registers
	logic [CAW-1:0] idx_q;
	logic [RAW-1:0] i_q, j_q;
	mstep_t         mcnt_q;
	logic [5:0]     kcnt_q;
	logic [CB-1:0]  total_q;
	logic           range_error_q, overflow_q, last_q, sat_q;
	tag_t           tag_s1;

	// payload registers
	logic [CAW-1:0]      ca_q;
	logic [RAW-1:0]      ra_q, rb_q;
	logic [CB-1:0]       o_q, sa_q, sb_q;
	logic [2*CB-1:0]     prod_s1, p_q, ot_q, diff_q;
	shift_t              sh_s1;
	logic [3*CB-1:0]     den_q;
	logic [4*CB-1:0]     num_q;
	logic [WW-1:0]       rem_q, dvs_q;
	logic [QUO_BITS-1:0] quo_q, sum_q, sum_add;
	logic                sat_next, div_ge;

	// RAM ports
	logic           cell_we, row_we;
	logic [CAW-1:0] cell_waddr, cell_raddr;
	logic [RAW-1:0] ra_waddr, rb_waddr, ra_raddr, rb_raddr;
	logic [CB-1:0]  cell_wdata, ra_wdata, rb_wdata;
	logic [CB-1:0]  cell_rdata, ra_rdata, rb_rdata;

	// shared multiplier
	logic [CB-1:0] mul_x, mul_y;
	tag_t          mul_tag;
	shift_t        mul_sh;
	logic [4*CB-1:0] prod_w, prod_sh;

	// row classification
	assign accept   = start && !busy;
	assign bad      = (value_a > K_VAL) || (value_b > K_VAL);
	assign present  = (value_a != 8'd0) && (value_b != 8'd0);
	assign at_limit = total_q == COUNT_MAX;
	assign counted  = !bad && present && !at_limit;
	assign am1      = RAW'(value_a - 8'd1);
	assign bm1      = RAW'(value_b - 8'd1);
	assign cell_in  = CAW'(am1) * K_CELL + CAW'(bm1);

	// divider step and term accumulation
	assign div_ge   = rem_q >= dvs_q;
	assign sum_add  = sum_q + QUO_BITS'(quo_q[STAT_BITS-1:0]);
	assign sat_next = quo_q[QUO_BITS-1] || (sum_add > {1'b0, STAT_MAX});

	cspi_ram #(.WIDTH(CB), .DEPTH(CELLS)) u_cell_ram (
		.clk(clk), .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
		.raddr(cell_raddr), .rdata(cell_rdata)
	);

	cspi_ram #(.WIDTH(CB), .DEPTH(K)) u_suma_ram (
		.clk(clk), .we(row_we), .waddr(ra_waddr), .wdata(ra_wdata),
		.raddr(ra_raddr), .rdata(ra_rdata)
	);

	cspi_ram #(.WIDTH(CB), .DEPTH(K)) u_sumb_ram (
		.clk(clk), .we(row_we), .waddr(rb_waddr), .wdata(rb_wdata),
		.raddr(rb_raddr), .rdata(rb_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLR:   if (idx_q == LAST_CELL) state_d = ST_IDLE;
			ST_IDLE: begin
				if (accept) begin
					if (counted) state_d = ST_INC;
					else if (last_row) state_d = ST_BEGIN;
				end
			end
			ST_INC:   state_d = last_q ? ST_BEGIN : ST_IDLE;
			ST_BEGIN: state_d = (total_q == '0) ? ST_OUT : ST_RD;
			ST_RD:    state_d = ST_LAT;
			ST_LAT:   state_d = ST_MUL;
			ST_MUL: begin
				if (mcnt_q == MS_DEN0 && p_q == '0) state_d = ST_NEXT;
				else if (mcnt_q == MS_LOAD) state_d = ST_DIV;
			end
			ST_DIV:   if (kcnt_q == 6'd0) state_d = ST_ACC;
			ST_ACC:   state_d = sat_next ? ST_OUT : ST_NEXT;
			ST_NEXT:  state_d = (idx_q == LAST_CELL) ? ST_OUT : ST_RD;
			ST_OUT:   state_d = (total_q != '0) ? ST_CLR : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and RAM / multiplier controls
	always_comb begin
		busy       = state_q != ST_IDLE;
		done       = state_q == ST_OUT;
		statistic  = sat_q ? STAT_MAX : sum_q[STAT_BITS-1:0];
		no_data    = total_q == '0;
		range_error    = range_error_q;
		count_overflow = overflow_q;

		cell_raddr = (state_q == ST_IDLE) ? cell_in : idx_q;
		ra_raddr   = (state_q == ST_IDLE) ? am1 : i_q;
		rb_raddr   = (state_q == ST_IDLE) ? bm1 : j_q;

		cell_we    = 1'b0;
		row_we     = 1'b0;
		cell_waddr = ca_q;
		ra_waddr   = ra_q;
		rb_waddr   = rb_q;
		cell_wdata = cell_rdata + CB'(1);
		ra_wdata   = ra_rdata + CB'(1);
		rb_wdata   = rb_rdata + CB'(1);

		mul_x   = sa_q;
		mul_y   = sb_q;
		mul_tag = TAG_NONE;
		mul_sh  = SH0;

		unique case (state_q)
			ST_INC: begin
				cell_we = 1'b1;
				row_we  = 1'b1;
			end
			ST_CLR: begin
				cell_we    = 1'b1;
				row_we     = idx_q < K_CELL;
				cell_waddr = idx_q;
				ra_waddr   = idx_q[RAW-1:0];
				rb_waddr   = idx_q[RAW-1:0];
				cell_wdata = '0;
				ra_wdata   = '0;
				rb_wdata   = '0;
			end
			ST_MUL: begin
				case (mcnt_q)
					MS_P: mul_tag = TAG_P;
					MS_OT: begin
						mul_x = o_q; mul_y = total_q; mul_tag = TAG_OT;
					end
					MS_DEN0: begin
						mul_x = total_q; mul_y = p_q[CB-1:0]; mul_tag = TAG_DEN;
					end
					MS_DEN1: begin
						mul_x = total_q; mul_y = p_q[2*CB-1:CB];
						mul_tag = TAG_DEN; mul_sh = SH1;
					end
					MS_NUM0: begin
						mul_x = diff_q[CB-1:0]; mul_y = diff_q[CB-1:0]; mul_tag = TAG_NUM;
					end
					MS_NUM1: begin
						mul_x = diff_q[CB-1:0]; mul_y = diff_q[2*CB-1:CB];
						mul_tag = TAG_NUM; mul_sh = SH1;
					end
					MS_NUM2: begin
						mul_x = diff_q[2*CB-1:CB]; mul_y = diff_q[CB-1:0];
						mul_tag = TAG_NUM; mul_sh = SH1;
					end
					MS_NUM3: begin
						mul_x = diff_q[2*CB-1:CB]; mul_y = diff_q[2*CB-1:CB];
						mul_tag = TAG_NUM; mul_sh = SH2;
					end
					default: mul_tag = TAG_NONE;
				endcase
			end
			default: mul_tag = TAG_NONE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLR;
			idx_q         <= '0;
			i_q           <= '0;
			j_q           <= '0;
			mcnt_q        <= MS_P;
			kcnt_q        <= '0;
			total_q       <= '0;
			range_error_q <= 1'b0;
			overflow_q    <= 1'b0;
			last_q        <= 1'b0;
			sat_q         <= 1'b0;
			tag_s1        <= TAG_NONE;
		end else begin
			state_q <= state_d;
			tag_s1  <= mul_tag;
			case (state_q)
				ST_CLR: idx_q <= (idx_q == LAST_CELL) ? '0 : idx_q + CAW'(1);
				ST_IDLE: begin
					if (accept) begin
						last_q <= last_row;
						if (bad) range_error_q <= 1'b1;
						else if (present && at_limit) overflow_q <= 1'b1;
						if (counted) total_q <= total_q + CB'(1);
					end
				end
				ST_BEGIN: begin
					idx_q <= '0;
					i_q   <= '0;
					j_q   <= '0;
					sat_q <= 1'b0;
				end
				ST_LAT: mcnt_q <= MS_P;
				ST_MUL: begin
					mcnt_q <= mcnt_q + 4'd1;
					kcnt_q <= 6'(QUO_BITS - 1);
				end
				ST_DIV: kcnt_q <= kcnt_q - 6'd1;
				ST_ACC: sat_q <= sat_next;
				ST_NEXT: begin
					idx_q <= idx_q + CAW'(1);
					if (j_q == LAST_IDX) begin
						j_q <= '0;
						i_q <= i_q + RAW'(1);
					end else begin
						j_q <= j_q + RAW'(1);
					end
				end
				ST_OUT: begin
					idx_q         <= '0;
					total_q       <= '0;
					range_error_q <= 1'b0;
					overflow_q    <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// shifted partial product
	assign prod_w = (4*CB)'(prod_s1);
	always_comb begin
		case (sh_s1)
			SH1:     prod_sh = prod_w << CB;
			SH2:     prod_sh = prod_w << (2 * CB);
			default: prod_sh = prod_w;
		endcase
	end

	// datapath: multiplier, accumulators, divider, term sum
	always_ff @(posedge clk) begin
		prod_s1 <= (2*CB)'(mul_x) * (2*CB)'(mul_y);
		sh_s1   <= mul_sh;

		if (accept) begin
			ca_q <= cell_in;
			ra_q <= am1;
			rb_q <= bm1;
		end

		if (state_q == ST_LAT) begin
			o_q   <= cell_rdata;
			sa_q  <= ra_rdata;
			sb_q  <= rb_rdata;
			num_q <= '0;
			den_q <= '0;
		end else begin
			case (tag_s1)
				TAG_P:   p_q   <= prod_s1;
				TAG_OT:  ot_q  <= prod_s1;
				TAG_DEN: den_q <= den_q + (3*CB)'(prod_sh);
				TAG_NUM: num_q <= num_q + prod_sh;
				default: ;
			endcase
		end

		if (state_q == ST_MUL && mcnt_q == MS_DEN1) begin
			diff_q <= (p_q > ot_q) ? p_q - ot_q : ot_q - p_q;
		end

		// restoring division of num * 2^16 by den, one quotient bit a cycle
		if (state_q == ST_MUL && mcnt_q == MS_LOAD) begin
			rem_q <= WW'(num_q) << FRAC_BITS;
			dvs_q <= WW'(den_q) << (QUO_BITS - 1);
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			if (div_ge) rem_q <= rem_q - dvs_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[QUO_BITS-2:0], div_ge};
		end

		if (state_q == ST_BEGIN) sum_q <= '0;
		else if (state_q == ST_ACC) sum_q <= sum_add;
	end

	`CSPI_ASSERT_NXT(a_accept_busy, accept && (counted || last_row), busy)
	`CSPI_ASSERT_NXT(a_done_pulse, done, !done)
	`CSPI_ASSERT_IMP(a_nodata_zero, done && no_data, statistic == '0)
	`CSPI_ASSERT_NXT(a_clear_after, done, total_q == '0 && !range_error_q && !overflow_q)
	`CSPI_ASSERT_IMP(a_inc_nonzero, state_q == ST_INC, cell_wdata != '0)

endmodule
